/* sv/mfd_pkg.sv */
// Package of the modem frame deframer: codes, item structs, configuration struct
// and small helper functions shared by the front, back and top modules of the block.
// Depends on nothing.
package mfd_pkg;

	localparam int MFD_MAX_HEADER_BYTES = 6;
	localparam int MFD_MID_DEPTH = 4;
	localparam int MFD_RES_DEPTH = 2;

	localparam logic [7:0] START_BYTE = 8'h7F;
	localparam logic [7:0] END_BYTE = 8'h7E;

	localparam int LIMIT_W = 13;
	localparam int CFG_DATA_W = 13;
	localparam int CFG_INDEX_W = 2;
	localparam int HCOUNT_W = 3;
	localparam logic [HCOUNT_W-1:0] HCOUNT_MAX = 3'd7;
	localparam logic [HCOUNT_W-1:0] RAW_CHANNEL_READY = 3'd4;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(4096 - 512);
	localparam logic [LIMIT_W-1:0] LIMIT_FLOOR = LIMIT_W'(1);

	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_FORMAT = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_PAD_ENABLE = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_SEGMENT_LIMIT = 2'd2;

	typedef enum logic [1:0] {
		FMT_FMT = 2'd0,
		FMT_RAW = 2'd1,
		FMT_MULTI_RAW = 2'd2,
		FMT_RFS = 2'd3
	} frame_format_t;

	typedef enum logic [1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_GOOD = 2'd1,
		KIND_ERROR = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ERR_NONE = 2'd0,
		ERR_START = 2'd1,
		ERR_END = 2'd2,
		ERR_LENGTH = 2'd3
	} err_t;

	typedef enum logic [2:0] {
		PH_HUNT = 3'd0,
		PH_HEADER = 3'd1,
		PH_HPAD = 3'd2,
		PH_PAYLOAD = 3'd3,
		PH_DPAD = 3'd4,
		PH_END = 3'd5,
		PH_EPAD = 3'd6,
		PH_DISCARD = 3'd7
	} phase_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic chunk_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic chunk_last;
		logic is_start;
		logic is_end;
	} mid_item_t;

	typedef struct packed {
		kind_t kind;
		logic [7:0] data;
		logic [7:0] channel;
		err_t error_code;
		logic segment_last;
	} res_item_t;

	typedef struct packed {
		frame_format_t frame_format;
		logic pad_enable;
		logic [LIMIT_W-1:0] segment_limit;
	} cfg_t;

	function automatic logic [HCOUNT_W-1:0] hdr_size(input frame_format_t fmt);
		logic [HCOUNT_W-1:0] size;
		unique case (fmt)
			FMT_FMT: size = 3'd3;
			FMT_RFS: size = 3'd6;
			default: size = 3'd4;
		endcase
		return size;
	endfunction

	function automatic logic is_raw(input frame_format_t fmt);
		return (fmt == FMT_RAW) || (fmt == FMT_MULTI_RAW);
	endfunction

endpackage

/* sv/mfd_queue.sv */
// Small register queue used between the halves of the deframer and for results.
// Depends on nothing; width and depth are parameters.
module mfd_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic do_wr;
	logic do_rd;

	assign full = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			unique case ({do_wr, do_rd})
				2'b10: count_q <= count_q + CNT_W'(1);
				2'b01: count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count above depth");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full && !do_rd |=> full)
		else $error("full queue lost an entry without a read");
	a_ptr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(int'(wr_ptr_q) < DEPTH) && (int'(rd_ptr_q) < DEPTH))
		else $error("queue pointer beyond depth");
`endif

endmodule

/* sv/mfd_front.sv */
// Front half of the deframer: accepts received bytes, marks start and end bytes
// and queues them for the framing half. Depends on mfd_pkg and mfd_queue.
module mfd_front
	import mfd_pkg::*;
#(
	parameter int MID_DEPTH = MFD_MID_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	output logic      full,
	input  in_item_t  item,
	input  logic      mid_pop,
	output mid_item_t mid_item,
	output logic      mid_empty
);

	localparam int MID_W = $bits(mid_item_t);

	mid_item_t classified;
	logic [MID_W-1:0] mid_raw;

	always_comb begin
		classified.rx_byte = item.rx_byte;
		classified.chunk_last = item.chunk_last;
		classified.is_start = (item.rx_byte == START_BYTE);
		classified.is_end = (item.rx_byte == END_BYTE);
	end

	mfd_queue #(
		.WIDTH(MID_W),
		.DEPTH(MID_DEPTH)
	) u_mid_queue (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(push),
		.wr_data(classified),
		.full(full),
		.rd_en(mid_pop),
		.rd_data(mid_raw),
		.empty(mid_empty)
	);

	assign mid_item = mid_item_t'(mid_raw);

endmodule

/* sv/mfd_back.sv */
// Back half of the deframer: the framing state machine, header store, counters
// and the result queue. Depends on mfd_pkg and mfd_queue.
module mfd_back
	import mfd_pkg::*;
#(
	parameter int MAX_HEADER_BYTES = MFD_MAX_HEADER_BYTES,
	parameter int RES_DEPTH = MFD_RES_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  mid_item_t mid_item,
	input  logic      mid_empty,
	output logic      mid_pop,
	output res_item_t result,
	output logic      empty,
	input  logic      pop
);

	localparam int HIDX_W = $clog2(MAX_HEADER_BYTES);
	localparam int RES_W = $bits(res_item_t);

	phase_t phase_q;
	phase_t phase_d;
	logic [7:0] hb_q [MAX_HEADER_BYTES];
	logic [HCOUNT_W-1:0] hc_q;
	logic [31:0] pc_q;
	logic [31:0] ds_q;
	logic [LIMIT_W-1:0] sc_q;

	logic go;
	logic res_full;
	logic [RES_W-1:0] res_raw;
	logic raw;
	logic pads;
	logic [LIMIT_W-1:0] eff_limit;
	logic [HCOUNT_W-1:0] hs;
	logic [HCOUNT_W-1:0] hc_inc;
	logic [HCOUNT_W-1:0] hc_eff;
	logic hdr_done;
	logic [7:0] hv [4];
	logic [31:0] len;
	logic [31:0] ds;
	logic len_bad;
	logic [31:0] pc_inc;
	logic pay_done;
	logic [LIMIT_W-1:0] sc_inc;
	logic seg_hit;
	logic tick;
	logic tick_done;
	logic emit;
	res_item_t res_d;

	assign go = !mid_empty && !res_full;
	assign mid_pop = go;

	assign raw = is_raw(cfg.frame_format);
	assign pads = cfg.pad_enable && raw;
	assign eff_limit = (cfg.segment_limit == '0) ? LIMIT_FLOOR : cfg.segment_limit;
	assign hs = hdr_size(cfg.frame_format);

	assign hc_inc = (hc_q < HCOUNT_MAX) ? hc_q + HCOUNT_W'(1) : hc_q;
	assign hdr_done = (hc_inc >= hs);
	assign hc_eff = (phase_q == PH_HEADER) ? hc_inc : hc_q;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			hv[i] = ((phase_q == PH_HEADER) && (hc_q == HCOUNT_W'(i))) ? mid_item.rx_byte
				: hb_q[i];
		end
	end

	always_comb begin
		len = {16'h0000, hv[1], hv[0]};
		if (cfg.frame_format == FMT_RFS) begin
			len[31:16] = {hv[3], hv[2]};
		end
	end

	assign ds = len - 32'(hs);
	assign len_bad = (len < 32'(hs))
		|| ((cfg.frame_format == FMT_MULTI_RAW) && (ds > 32'(eff_limit)));

	assign pc_inc = pc_q + 32'd1;
	assign pay_done = (pc_inc >= ds_q);

	assign sc_inc = sc_q + LIMIT_W'(1);
	assign seg_hit = tick_done || (sc_inc >= eff_limit);

	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			PH_HUNT: begin
				if (mid_item.is_start) begin
					phase_d = PH_HEADER;
				end else begin
					phase_d = mid_item.chunk_last ? PH_HUNT : PH_DISCARD;
				end
			end
			PH_HEADER: begin
				if (!hdr_done) begin
					phase_d = PH_HEADER;
				end else if (len_bad) begin
					phase_d = mid_item.chunk_last ? PH_HUNT : PH_DISCARD;
				end else if (pads) begin
					phase_d = PH_HPAD;
				end else begin
					phase_d = (ds == 32'd0) ? PH_END : PH_PAYLOAD;
				end
			end
			PH_HPAD: phase_d = (ds_q == 32'd0) ? PH_END : PH_PAYLOAD;
			PH_PAYLOAD: begin
				if (pay_done) begin
					phase_d = (pads && ds_q[0]) ? PH_DPAD : PH_END;
				end
			end
			PH_DPAD: phase_d = PH_END;
			PH_END: begin
				if (mid_item.is_end) begin
					phase_d = pads ? PH_EPAD : PH_HUNT;
				end else begin
					phase_d = mid_item.chunk_last ? PH_HUNT : PH_DISCARD;
				end
			end
			PH_EPAD: phase_d = PH_HUNT;
			PH_DISCARD: phase_d = mid_item.chunk_last ? PH_HUNT : PH_DISCARD;
			default: phase_d = PH_HUNT;
		endcase
	end

	always_comb begin
		emit = 1'b0;
		tick = 1'b0;
		tick_done = 1'b0;
		res_d.kind = KIND_PAYLOAD;
		res_d.data = 8'h00;
		res_d.error_code = ERR_NONE;
		unique case (phase_q)
			PH_HUNT: begin
				if (!mid_item.is_start) begin
					emit = 1'b1;
					res_d.kind = KIND_ERROR;
					res_d.error_code = ERR_START;
				end
			end
			PH_HEADER: begin
				if (hdr_done && len_bad) begin
					emit = 1'b1;
					res_d.kind = KIND_ERROR;
					res_d.error_code = ERR_LENGTH;
				end else if (cfg.frame_format == FMT_RFS) begin
					emit = 1'b1;
					tick = 1'b1;
					tick_done = hdr_done && (ds == 32'd0);
					res_d.data = mid_item.rx_byte;
				end
			end
			PH_PAYLOAD: begin
				emit = 1'b1;
				tick = 1'b1;
				tick_done = pay_done;
				res_d.data = mid_item.rx_byte;
			end
			PH_END: begin
				emit = 1'b1;
				if (mid_item.is_end) begin
					res_d.kind = KIND_GOOD;
				end else begin
					res_d.kind = KIND_ERROR;
					res_d.error_code = ERR_END;
				end
			end
			default: emit = 1'b0;
		endcase
		res_d.segment_last = tick && seg_hit;
		res_d.channel = (raw && (hc_eff >= RAW_CHANNEL_READY)) ? hv[2] : 8'h00;
	end

	always_ff @(posedge clk) begin
		if (go && (phase_q == PH_HEADER) && (int'(hc_q) < MAX_HEADER_BYTES)) begin
			hb_q[hc_q[HIDX_W-1:0]] <= mid_item.rx_byte;
		end
		if (go && (phase_q == PH_HEADER) && hdr_done) begin
			ds_q <= ds;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			hc_q <= '0;
			pc_q <= '0;
			sc_q <= '0;
		end else if (go) begin
			phase_q <= phase_d;
			if ((phase_q == PH_HUNT) && mid_item.is_start) begin
				hc_q <= '0;
				pc_q <= '0;
			end
			if (phase_q == PH_HEADER) begin
				hc_q <= hc_inc;
				if (hdr_done) begin
					pc_q <= '0;
				end
			end
			if (phase_q == PH_PAYLOAD) begin
				pc_q <= pc_inc;
			end
			if (tick) begin
				sc_q <= seg_hit ? '0 : sc_inc;
			end else if ((phase_q == PH_HUNT) && mid_item.is_start) begin
				sc_q <= '0;
			end
		end
	end

	mfd_queue #(
		.WIDTH(RES_W),
		.DEPTH(RES_DEPTH)
	) u_res_queue (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(go && emit),
		.wr_data(res_d),
		.full(res_full),
		.rd_en(pop),
		.rd_data(res_raw),
		.empty(empty)
	);

	assign result = res_item_t'(res_raw);

`ifndef NO_ASSERTIONS
	a_seg_only_payload: assert property (@(posedge clk) disable iff (!arst_n)
		go && emit && (res_d.kind != KIND_PAYLOAD) |-> !res_d.segment_last)
		else $error("segment end marked on a non-payload result");
	a_error_discards: assert property (@(posedge clk) disable iff (!arst_n)
		go && emit && (res_d.kind == KIND_ERROR) && !mid_item.chunk_last
		|=> phase_q == PH_DISCARD)
		else $error("error inside a transfer did not start discarding");
	a_payload_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAYLOAD |-> pc_q < ds_q)
		else $error("payload count reached the length while in payload");
	a_channel_raw: assert property (@(posedge clk) disable iff (!arst_n)
		go && emit && !raw |-> res_d.channel == 8'h00)
		else $error("channel reported for a format without channels");
`endif

endmodule

/* sv/modem_frame_deframer.sv */
// Top level of the modem frame deframer: configuration registers and the front
// and back halves. Depends on mfd_pkg, mfd_front and mfd_back.
//
// The deframer takes one received link byte per clock cycle while full is low and
// gives at most one result item per byte: a payload byte with its channel and
// segment end mark, a good-frame marker or an error marker. Bytes enter a queue of
// MID_DEPTH entries after start and end bytes have been marked; the framing state
// machine behind it handles one byte per cycle, so the sustained rate is one item
// per cycle while results are taken. A byte passes through that queue and then the
// result queue of RES_DEPTH entries, which lets a new byte be taken while a result
// still waits. Configuration must be written only while the block is idle.
module modem_frame_deframer
	import mfd_pkg::*;
#(
	parameter int MAX_HEADER_BYTES = MFD_MAX_HEADER_BYTES,
	parameter int MID_DEPTH = MFD_MID_DEPTH,
	parameter int RES_DEPTH = MFD_RES_DEPTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	output logic                   full,
	input  in_item_t               item,
	output logic                   empty,
	input  logic                   pop,
	output res_item_t              result,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	frame_format_t frame_format_q;
	logic pad_enable_q;
	logic [LIMIT_W-1:0] segment_limit_q;
	cfg_t cfg;
	mid_item_t mid_item;
	logic mid_empty;
	logic mid_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_format_q <= FMT_FMT;
			pad_enable_q <= 1'b0;
			segment_limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FRAME_FORMAT: frame_format_q <= frame_format_t'(cfg_data[1:0]);
				REG_PAD_ENABLE: pad_enable_q <= cfg_data[0];
				REG_SEGMENT_LIMIT: segment_limit_q <= cfg_data[LIMIT_W-1:0];
				default: segment_limit_q <= segment_limit_q;
			endcase
		end
	end

	always_comb begin
		cfg.frame_format = frame_format_q;
		cfg.pad_enable = pad_enable_q;
		cfg.segment_limit = segment_limit_q;
	end

	mfd_front #(
		.MID_DEPTH(MID_DEPTH)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.item(item),
		.mid_pop(mid_pop),
		.mid_item(mid_item),
		.mid_empty(mid_empty)
	);

	mfd_back #(
		.MAX_HEADER_BYTES(MAX_HEADER_BYTES),
		.RES_DEPTH(RES_DEPTH)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.mid_item(mid_item),
		.mid_empty(mid_empty),
		.mid_pop(mid_pop),
		.result(result),
		.empty(empty),
		.pop(pop)
	);

endmodule
